>>> rtl/flow_sensor_frame_checker_unit_assert.svh
// Assertion macros for the flow sensor frame checker verification files.
`ifndef FLOW_SENSOR_FRAME_CHECKER_UNIT_ASSERT_SVH
`define FLOW_SENSOR_FRAME_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FSFC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSFC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays armed through reset.
`define FSFC_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fsfc_pkg.sv
// Shared constants, types and CRC function for the flow sensor frame checker.
`timescale 1ns / 1ps
`default_nettype none

package fsfc_pkg;

    localparam int FRAME_BYTES = 9;
    localparam logic [3:0] LAST_BYTE_IDX = 4'(FRAME_BYTES - 1);

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // byte position inside one word
    localparam logic [1:0] POS_HIGH = 2'd0;
    localparam logic [1:0] POS_LOW  = 2'd1;
    localparam logic [1:0] POS_CRC  = 2'd2;

    // configuration register indexes
    localparam logic REG_FLOW_ZERO = 1'b0;
    localparam logic REG_TEMP_ZERO = 1'b1;

    localparam logic [15:0] FLOW_ZERO_RST = 16'h9000;  // -28672
    localparam logic [15:0] TEMP_ZERO_RST = 16'h0000;

    // result error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_CRC   = 2'd1;
    localparam logic [1:0] ERR_SHORT = 2'd2;

    // x / 25 == (x * 83887) >> 21, exact for 0 <= x < 2^16
    localparam logic [16:0] FLOW_RECIP       = 17'd83887;
    localparam int          FLOW_RECIP_SHIFT = 21;

    localparam int DEF_QUEUE_DEPTH = 4;

    // event handed from the byte parser to the conversion side
    typedef struct packed {
        logic        is_short;
        logic [2:0]  fail_mask;
        logic [15:0] word0;
        logic [15:0] word1;
        logic [15:0] word2;
    } t_evt;

    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/fsfc_front.sv
// Byte parser: frame tracking, CRC check and word capture.
`timescale 1ns / 1ps
`default_nettype none

module fsfc_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_start,
    input  wire logic          i_q_full,
    output logic               o_push,
    output fsfc_pkg::t_evt     o_evt
);
    import fsfc_pkg::*;

    logic [3:0]  r_idx,  n_idx;
    logic [1:0]  r_pos,  n_pos;
    logic [1:0]  r_word, n_word;
    logic [7:0]  r_crc,  n_crc;
    logic [7:0]  r_hi,   n_hi;
    logic [2:0]  r_fail, n_fail;
    logic [15:0] r_wb [3];

    logic       accept;
    logic       active;
    logic       wb_we;
    logic       push_short;
    logic       push_frame;
    logic [3:0] c_idx;
    logic [1:0] c_pos;
    logic [1:0] c_word;
    logic [2:0] c_fail;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    always_comb begin
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_word     = r_word;
        n_crc      = r_crc;
        n_hi       = r_hi;
        n_fail     = r_fail;
        wb_we      = 1'b0;
        push_short = 1'b0;
        push_frame = 1'b0;
        active     = 1'b0;
        c_idx      = r_idx;
        c_pos      = r_pos;
        c_word     = r_word;
        c_fail     = r_fail;

        if (accept) begin
            if (i_start) begin
                // a start inside a frame cuts it short; the byte opens a new one
                push_short = (r_idx != 4'd0);
                c_idx      = 4'd0;
                c_pos      = POS_HIGH;
                c_word     = 2'd0;
                c_fail     = 3'b000;
                active     = 1'b1;
            end else begin
                active = (r_idx != 4'd0);
            end
        end

        if (active) begin
            case (c_pos)
                POS_HIGH: begin
                    n_crc = crc8_update(CRC_INIT, i_byte);
                    n_hi  = i_byte;
                end
                POS_LOW: begin
                    n_crc = crc8_update(r_crc, i_byte);
                    wb_we = 1'b1;
                end
                default: begin
                    if (r_crc != i_byte) begin
                        c_fail = c_fail | (3'b001 << c_word);
                    end
                    n_crc = CRC_INIT;
                end
            endcase

            if (c_idx == LAST_BYTE_IDX) begin
                push_frame = 1'b1;
                n_idx      = 4'd0;
                n_pos      = POS_HIGH;
                n_word     = 2'd0;
                n_fail     = 3'b000;
            end else begin
                n_idx  = c_idx + 4'd1;
                n_pos  = (c_pos == POS_CRC) ? POS_HIGH : c_pos + 2'd1;
                n_word = (c_pos == POS_CRC) ? c_word + 2'd1 : c_word;
                n_fail = c_fail;
            end
        end
    end

    assign o_push             = push_short || push_frame;
    assign o_evt.is_short     = push_short;
    assign o_evt.fail_mask    = c_fail;
    assign o_evt.word0        = r_wb[0];
    assign o_evt.word1        = r_wb[1];
    assign o_evt.word2        = r_wb[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= 4'd0;
            r_pos  <= POS_HIGH;
            r_word <= 2'd0;
            r_crc  <= CRC_INIT;
            r_hi   <= 8'd0;
            r_fail <= 3'b000;
        end else begin
            r_idx  <= n_idx;
            r_pos  <= n_pos;
            r_word <= n_word;
            r_crc  <= n_crc;
            r_hi   <= n_hi;
            r_fail <= n_fail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wb_we) begin
            r_wb[c_word] <= {r_hi, i_byte};
        end
    end

endmodule

`default_nettype wire

>>> rtl/fsfc_queue.sv
// Small event queue between the byte parser and the conversion side.
`timescale 1ns / 1ps
`default_nettype none

module fsfc_queue #(
    parameter int DEPTH = fsfc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire fsfc_pkg::t_evt  i_evt,
    output logic                 o_full,
    output logic                 o_valid,
    input  wire logic            i_pop,
    output fsfc_pkg::t_evt       o_evt
);
    import fsfc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_evt             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_evt   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_evt;
        end
    end

endmodule

`default_nettype wire

>>> rtl/fsfc_back.sv
// Conversion side: offset, scaling, last-good tracking and result register.
`timescale 1ns / 1ps
`default_nettype none

module fsfc_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [15:0]   i_flow_zero,
    input  wire logic [15:0]   i_temp_zero,
    input  wire logic          i_q_valid,
    output logic               o_pop,
    input  wire fsfc_pkg::t_evt i_evt,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [12:0]        o_flow,
    output logic [15:0]        o_temp,
    output logic [15:0]        o_status,
    output logic [2:0]         o_mask,
    output logic [1:0]         o_code
);
    import fsfc_pkg::*;

    // stage 1: offsets applied
    logic        r_s1_valid;
    logic        r_s1_short;
    logic [2:0]  r_s1_mask;
    logic [15:0] r_s1_flow_mag;
    logic        r_s1_flow_neg;
    logic [15:0] r_s1_temp;
    logic [15:0] r_s1_status;

    // result register and last good values
    logic        r_out_valid;
    logic [12:0] r_out_flow;
    logic [15:0] r_out_temp;
    logic [15:0] r_out_status;
    logic [2:0]  r_out_mask;
    logic [1:0]  r_out_code;
    logic [12:0] r_good_flow;
    logic [15:0] r_good_temp;
    logic [15:0] r_good_status;

    logic        out_free;
    logic        s1_free;
    logic [16:0] flow_diff;
    logic [16:0] flow_abs;
    logic [16:0] temp_diff;
    logic [16:0] temp_bias;
    logic [32:0] flow_prod;
    logic [11:0] flow_quot;
    logic [12:0] flow_val;

    assign out_free = !r_out_valid || i_ready;
    assign s1_free  = !r_s1_valid || out_free;
    assign o_pop    = i_q_valid && s1_free;

    // 17-bit signed differences cannot overflow
    assign flow_diff = {i_evt.word0[15], i_evt.word0} - {i_flow_zero[15], i_flow_zero};
    assign flow_abs  = flow_diff[16] ? (17'd0 - flow_diff) : flow_diff;
    assign temp_diff = {i_evt.word1[15], i_evt.word1} - {i_temp_zero[15], i_temp_zero};
    // add one before the shift on negatives so the halving truncates toward zero
    assign temp_bias = temp_diff + {16'd0, temp_diff[16]};

    assign flow_prod = 33'(r_s1_flow_mag) * 33'(FLOW_RECIP);
    assign flow_quot = 12'(flow_prod >> FLOW_RECIP_SHIFT);
    assign flow_val  = r_s1_flow_neg ? (13'd0 - {1'b0, flow_quot}) : {1'b0, flow_quot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_good_flow   <= 13'd0;
            r_good_temp   <= 16'd0;
            r_good_status <= 16'd0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_q_valid;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
                if (r_s1_valid && !r_s1_short && (r_s1_mask == 3'b000)) begin
                    r_good_flow   <= flow_val;
                    r_good_temp   <= r_s1_temp;
                    r_good_status <= r_s1_status;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1_short    <= i_evt.is_short;
            r_s1_mask     <= i_evt.fail_mask;
            r_s1_flow_mag <= flow_abs[15:0];
            r_s1_flow_neg <= flow_diff[16];
            r_s1_temp     <= temp_bias[16:1];
            r_s1_status   <= i_evt.word2;
        end
        if (out_free && r_s1_valid) begin
            if (r_s1_short) begin
                r_out_flow   <= r_good_flow;
                r_out_temp   <= r_good_temp;
                r_out_status <= r_good_status;
                r_out_mask   <= 3'b000;
                r_out_code   <= ERR_SHORT;
            end else if (r_s1_mask == 3'b000) begin
                r_out_flow   <= flow_val;
                r_out_temp   <= r_s1_temp;
                r_out_status <= r_s1_status;
                r_out_mask   <= 3'b000;
                r_out_code   <= ERR_OK;
            end else begin
                r_out_flow   <= r_good_flow;
                r_out_temp   <= r_good_temp;
                r_out_status <= r_good_status;
                r_out_mask   <= r_s1_mask;
                r_out_code   <= ERR_CRC;
            end
        end
    end

    assign o_valid  = r_out_valid;
    assign o_flow   = r_out_flow;
    assign o_temp   = r_out_temp;
    assign o_status = r_out_status;
    assign o_mask   = r_out_mask;
    assign o_code   = r_out_code;

endmodule

`default_nettype wire

>>> rtl/flow_sensor_frame_checker_unit.sv
// Top level of the flow sensor frame checker: config registers and datapath assembly.
//
//  Channel   Direction  Payload                                     Handshake
//  s_axis    in         tdata: rx_byte; tuser: frame_start          tvalid/tready
//  m_axis    out        tdata: flow, temp, status; tuser: mask,code tvalid/tready
//  cfg       in         index 0 flow zero point, 1 temp zero point  write enable only
//
// One byte transaction per cycle while the event queue is not full. After its ninth
// byte, a frame result passes through the event queue and the offset stage, then the
// result register (the /25 multiply sits before it), onto m_axis.
// s_axis_tready drops only when the event queue is full; the queue and the
// result register let the parser keep taking bytes while a result is stalled.
// Reset is synchronous, active low; no clearing pass is needed after it.
`timescale 1ns / 1ps
`default_nettype none

module flow_sensor_frame_checker_unit #(
    parameter int QUEUE_DEPTH = fsfc_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // byte input
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [7:0]    s_axis_tdata,   // [7:0] rx_byte
    input  wire logic [0:0]    s_axis_tuser,   // [0] frame_start
    // result output
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [47:0]        m_axis_tdata,   // [12:0] flow_centi_slm, [28:13] temp_centi_c,
                                               // [44:29] status_word, [47:45] zero
    output logic [4:0]         m_axis_tuser,   // [2:0] crc_fail_mask, [4:3] error_code
    // configuration writes
    input  wire logic          i_cfg_wr_en,
    input  wire logic [0:0]    i_cfg_wr_idx,
    input  wire logic [15:0]   i_cfg_wr_data
);
    import fsfc_pkg::*;

    logic [15:0] r_flow_zero;
    logic [15:0] r_temp_zero;

    t_evt        push_evt;
    t_evt        head_evt;
    logic        push;
    logic        q_full;
    logic        q_valid;
    logic        pop;

    logic [12:0] res_flow;
    logic [15:0] res_temp;
    logic [15:0] res_status;
    logic [2:0]  res_mask;
    logic [1:0]  res_code;

    // offsets are to change only while idle (the block does not enforce it), so the back end reads them directly
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_zero <= FLOW_ZERO_RST;
            r_temp_zero <= TEMP_ZERO_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_wr_idx[0])
                REG_FLOW_ZERO: r_flow_zero <= i_cfg_wr_data;
                REG_TEMP_ZERO: r_temp_zero <= i_cfg_wr_data;
                default: ;
            endcase
        end
    end

    // front: frame tracking and CRC, one event per finished or cut-short frame
    fsfc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_byte   (s_axis_tdata),
        .i_start  (s_axis_tuser[0]),
        .i_q_full (q_full),
        .o_push   (push),
        .o_evt    (push_evt)
    );

    fsfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_evt   (head_evt)
    );

    // back: conversion and last-good bookkeeping
    fsfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_flow_zero (r_flow_zero),
        .i_temp_zero (r_temp_zero),
        .i_q_valid   (q_valid),
        .o_pop       (pop),
        .i_evt       (head_evt),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_flow      (res_flow),
        .o_temp      (res_temp),
        .o_status    (res_status),
        .o_mask      (res_mask),
        .o_code      (res_code)
    );

    assign m_axis_tdata = {3'b000, res_status, res_temp, res_flow};
    assign m_axis_tuser = {res_code, res_mask};

endmodule

`default_nettype wire

>>> rtl/fsfc_checker.sv
// Port-level assertions for the flow sensor frame checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "flow_sensor_frame_checker_unit_assert.svh"

module fsfc_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire logic [47:0]   i_m_tdata,
    input  wire logic [4:0]    i_m_tuser
);
    import fsfc_pkg::*;

    logic [44:0] r_last_good;
    logic [2:0]  mask;
    logic [1:0]  code;
    logic        m_acc;

    assign mask  = i_m_tuser[2:0];
    assign code  = i_m_tuser[4:3];
    assign m_acc = i_m_tvalid && i_m_tready;

    // values of the last delivered good result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_good <= '0;
        end else if (m_acc && (code == ERR_OK)) begin
            r_last_good <= i_m_tdata[44:0];
        end
    end

    `FSFC_ASSERT_NXT_ALWAYS(a_reset_clears_valid, i_clk, !i_rst_n, !i_m_tvalid, "result valid right after reset")
    `FSFC_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n, i_m_tvalid && !i_m_tready, i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser), "stalled result changed")
    `FSFC_ASSERT_IMP(a_code_mask, i_clk, i_rst_n, i_m_tvalid, (code == ERR_OK && mask == 3'b000) || (code == ERR_CRC && mask != 3'b000) || (code == ERR_SHORT && mask == 3'b000), "error code and fail mask disagree")
    `FSFC_ASSERT_IMP(a_err_repeats_good, i_clk, i_rst_n, m_acc && (code != ERR_OK), i_m_tdata[44:0] == r_last_good, "error result does not repeat last good values")

endmodule

bind flow_sensor_frame_checker_unit fsfc_checker u_fsfc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

`default_nettype wire
